/* rtl/swt_pkg.sv */
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and character codes for the shell word tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package swt_pkg;

    localparam int unsigned MaxRun = 4;
    localparam int unsigned CntW   = $clog2(MaxRun + 1);

    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChDquote = 8'h22;
    localparam logic [7:0] ChSquote = 8'h27;
    localparam logic [7:0] ChBslash = 8'h5c;

    // one result of a run
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       wend;
        logic       lend;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

/* rtl/shell_word_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// shell_word_tokenizer_unit
// Quote-aware splitting of a command line into a stream of word results.
// ----------------------------------------------------------------------------
// Bytes of a command line enter one per item, with line_last on the final
// byte. Each item yields zero to four results (word bytes, a word-end marker,
// a line-end marker), the final one flagged by run_last. The lexer state is
// updated in the cycle an item is accepted, and its results are loaded into a
// four-entry result shift register that drains one result per cycle while
// out_ready is high. A new item is taken in the cycle the last result of
// the previous one leaves, so a new run can follow it without a gap.
// Zero-result items (quote characters, blanks between words, a pending
// backslash) produce no output.
`default_nettype none

module shell_word_tokenizer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       line_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      word_byte,
    output logic            byte_valid,
    output logic            word_end,
    output logic            line_end,
    output logic            run_last
);
    import swt_pkg::*;

    typedef enum logic [1:0] {
        MODE_OUT,
        MODE_WORD,
        MODE_DQ,
        MODE_SQ
    } mode_t;

    mode_t           mode_reg, mode_next;
    logic            esc_reg, esc_next;
    logic            nonempty_reg, nonempty_next;
    logic [CntW-1:0] cnt_reg;
    res_t            slot_reg [MaxRun];

    res_t            run_v [MaxRun];
    logic [CntW-1:0] n_v;
    logic            done_v;
    logic            blank;
    logic            in_fire;
    logic            out_fire;

    assign out_valid  = (cnt_reg != '0);
    assign out_fire   = out_valid && out_ready;
    assign in_ready   = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && out_ready);
    assign in_fire    = in_valid && in_ready;

    assign word_byte  = slot_reg[0].ch;
    assign byte_valid = slot_reg[0].valid;
    assign word_end   = slot_reg[0].wend;
    assign line_end   = slot_reg[0].lend;
    assign run_last   = slot_reg[0].last;

    assign blank = (in_byte == ChSpace) || (in_byte == ChTab);

    // lexer step: next state and the run of results for the byte on the input
    always_comb
    begin
        mode_next     = mode_reg;
        esc_next      = esc_reg;
        nonempty_next = nonempty_reg;
        n_v           = '0;
        done_v        = 1'b0;
        for (int i = 0; i < MaxRun; i++)
        begin
            run_v[i] = '0;
        end

        if (esc_reg)
        begin
            esc_next = 1'b0;
            if (mode_reg == MODE_DQ)
            begin
                if ((in_byte == ChDquote) || (in_byte == ChBslash))
                begin
                    run_v[n_v[1:0]] = '{ch: in_byte, valid: 1'b1, default: 1'b0};
                    n_v             = n_v + CntW'(1);
                    nonempty_next   = 1'b1;
                    done_v          = 1'b1;
                end
                else
                begin
                    // lone backslash inside double quotes stays literal
                    run_v[n_v[1:0]] = '{ch: ChBslash, valid: 1'b1, default: 1'b0};
                    n_v             = n_v + CntW'(1);
                    nonempty_next   = 1'b1;
                end
            end
            else
            begin
                run_v[n_v[1:0]] = '{ch: in_byte, valid: 1'b1, default: 1'b0};
                n_v             = n_v + CntW'(1);
                nonempty_next   = 1'b1;
                mode_next       = MODE_WORD;
                done_v          = 1'b1;
            end
        end

        if (!done_v)
        begin
            case (mode_reg)
                MODE_OUT, MODE_WORD:
                begin
                    if (blank)
                    begin
                        if (mode_reg == MODE_WORD)
                        begin
                            run_v[n_v[1:0]] = '{wend: 1'b1, default: '0};
                            n_v             = n_v + CntW'(1);
                            nonempty_next   = 1'b0;
                            mode_next       = MODE_OUT;
                        end
                    end
                    else if (in_byte == ChDquote)
                    begin
                        mode_next = MODE_DQ;
                    end
                    else if (in_byte == ChSquote)
                    begin
                        mode_next = MODE_SQ;
                    end
                    else if ((in_byte == ChBslash) && !line_last)
                    begin
                        esc_next  = 1'b1;
                        mode_next = MODE_WORD;
                    end
                    else
                    begin
                        run_v[n_v[1:0]] = '{ch: in_byte, valid: 1'b1, default: 1'b0};
                        n_v             = n_v + CntW'(1);
                        nonempty_next   = 1'b1;
                        mode_next       = MODE_WORD;
                    end
                end
                MODE_DQ:
                begin
                    if (in_byte == ChDquote)
                    begin
                        mode_next = MODE_WORD;
                    end
                    else if ((in_byte == ChBslash) && !line_last)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        run_v[n_v[1:0]] = '{ch: in_byte, valid: 1'b1, default: 1'b0};
                        n_v             = n_v + CntW'(1);
                        nonempty_next   = 1'b1;
                    end
                end
                default:
                begin
                    if (in_byte == ChSquote)
                    begin
                        mode_next = MODE_WORD;
                    end
                    else
                    begin
                        run_v[n_v[1:0]] = '{ch: in_byte, valid: 1'b1, default: 1'b0};
                        n_v             = n_v + CntW'(1);
                        nonempty_next   = 1'b1;
                    end
                end
            endcase
        end

        if (line_last)
        begin
            // an empty word with closed quotes is dropped at end of line
            if (nonempty_next || (mode_next == MODE_DQ) || (mode_next == MODE_SQ))
            begin
                run_v[n_v[1:0]] = '{wend: 1'b1, default: '0};
                n_v             = n_v + CntW'(1);
            end
            run_v[n_v[1:0]] = '{lend: 1'b1, default: '0};
            n_v             = n_v + CntW'(1);
            mode_next       = MODE_OUT;
            esc_next        = 1'b0;
            nonempty_next   = 1'b0;
        end

        for (int i = 0; i < MaxRun; i++)
        begin
            run_v[i].last = (n_v == CntW'(i + 1));
        end
    end

    // lexer state plus the result shift register, head at entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OUT;
            esc_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            cnt_reg      <= '0;
            for (int i = 0; i < MaxRun; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            mode_reg     <= mode_next;
            esc_reg      <= esc_next;
            nonempty_reg <= nonempty_next;
            cnt_reg      <= n_v;
            for (int i = 0; i < MaxRun; i++)
            begin
                slot_reg[i] <= run_v[i];
            end
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
            for (int i = 0; i < MaxRun - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
            slot_reg[MaxRun - 1] <= '0;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MaxRun))
        else $error("result count out of range");

    a_line_resets : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && line_last |=> (mode_reg == MODE_OUT) && !esc_reg && !nonempty_reg)
        else $error("lexer state not cleared after line end");

    a_line_end_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> run_last && (cnt_reg == CntW'(1)))
        else $error("line end is not the final result of its run");

    a_marker_no_byte : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (word_end || line_end) |-> !byte_valid && !(word_end && line_end))
        else $error("marker result carries a byte");

    a_last_drains : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |-> (cnt_reg == CntW'(1)))
        else $error("run_last shown before the run is drained");
`endif

endmodule

`default_nettype wire
